[rtl/quad_motor_mixer_core_assert.svh]
// Assertion macros for the motor mixer, clocked on i_clk, off during reset.
`ifndef QUAD_MOTOR_MIXER_CORE_ASSERT_SVH
`define QUAD_MOTOR_MIXER_CORE_ASSERT_SVH

// Condition that holds at every clock edge.
`define QMM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mixer check failed");

// Same-cycle implication.
`define QMM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed");

`endif

[rtl/qmm_pkg.sv]
package qmm_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int NUM_MOTORS = 4;

    // field widths
    localparam int U_W      = FRAC_BITS + 7;
    localparam int S_W      = FRAC_BITS + 8;
    // -p-r reaches +2^S_W, one bit past a plain sum of two fields
    localparam int D_W      = S_W + 2;
    localparam int RAW_W    = S_W + 3;
    localparam int SCALE_W  = 14;
    localparam int SCALED_W = U_W + 2;

    // percent levels
    localparam int HUNDRED = 100 << FRAC_BITS;
    localparam int NINETY  = 90 << FRAC_BITS;
    localparam int TWENTY  = 20 << FRAC_BITS;

    // X-frame diagonal weight, Q0.16
    localparam int DIAG_K     = 46341;
    localparam int DIAG_SHIFT = 16;
    localparam int DIAG_KW    = DIAG_SHIFT + 1;
    localparam int P_W        = D_W + DIAG_KW;

    // Linearisation: L = r*(9H + 11r) / (20H), 20H = 125 << (FRAC_BITS+4)
    localparam int    LIN_BASE    = 9 * HUNDRED;
    localparam int    LIN_TAIL    = 11;
    localparam int    LIN_HALF    = 10 * HUNDRED;
    localparam int    LIN_SHIFT   = FRAC_BITS + 4;
    localparam int    COEF_W      = FRAC_BITS + 11;
    localparam int    NUM_W       = U_W + COEF_W;
    localparam int    X_W         = FRAC_BITS + 14;
    localparam int    RECIP_SHIFT = X_W + 7;
    localparam int    RECIP_W     = X_W + 1;
    localparam longint RECIP      = ((longint'(1) << RECIP_SHIFT) + 124) / 125;

    // motor scale, Q2.12
    localparam int SCALE_SHIFT = 12;
    localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(410);
    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(12288);
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(4096);

    // configuration port
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_MODE = 3'd0,
        REG_SCALE_M1   = 3'd1,
        REG_SCALE_M2   = 3'd2,
        REG_SCALE_M3   = 3'd3,
        REG_SCALE_M4   = 3'd4
    } t_reg_idx;

    localparam logic FRAME_PLUS = 1'b0;
    localparam logic FRAME_X    = 1'b1;

    typedef struct packed {
        logic        [U_W-1:0] thrust_cmd;
        logic signed [S_W-1:0] roll_cmd;
        logic signed [S_W-1:0] pitch_cmd;
        logic signed [S_W-1:0] yaw_cmd;
    } t_cmd;

    typedef struct packed {
        logic [U_W-1:0]        motor1_out;
        logic [U_W-1:0]        motor2_out;
        logic [U_W-1:0]        motor3_out;
        logic [U_W-1:0]        motor4_out;
        logic [NUM_MOTORS-1:0] low_sat_flags;
        logic [NUM_MOTORS-1:0] high_sat_flags;
    } t_mix;

    // load enables of the per-motor stages
    typedef struct packed {
        logic clamp;
        logic lin_mul;
        logic recip;
        logic scale;
        logic sat;
    } t_lane_en;

endpackage

[rtl/qmm_motor.sv]
module qmm_motor (
    input  logic                                i_clk,
    input  qmm_pkg::t_lane_en                   i_en,
    input  logic signed [qmm_pkg::RAW_W-1:0]    i_raw,
    input  logic        [qmm_pkg::SCALE_W-1:0]  i_scale,
    output logic        [qmm_pkg::U_W-1:0]      o_motor,
    output logic                                o_low_sat,
    output logic                                o_high_sat
);

    localparam int U_W      = qmm_pkg::U_W;
    localparam int RAW_W    = qmm_pkg::RAW_W;
    localparam int COEF_W   = qmm_pkg::COEF_W;
    localparam int NUM_SW   = qmm_pkg::NUM_W + 1;
    localparam int X_W      = qmm_pkg::X_W;
    localparam int PL_W     = qmm_pkg::X_W + qmm_pkg::RECIP_W;
    localparam int PS_W     = qmm_pkg::U_W + qmm_pkg::SCALE_W + 1;
    localparam int SCALED_W = qmm_pkg::SCALED_W;

    localparam logic signed [RAW_W-1:0] RAW_FULL = RAW_W'(qmm_pkg::HUNDRED);
    localparam logic [U_W-1:0]      LIN_FULL   = U_W'(qmm_pkg::HUNDRED);
    localparam logic [COEF_W-1:0]   COEF_BASE  = COEF_W'(qmm_pkg::LIN_BASE);
    localparam logic [COEF_W-1:0]   COEF_TAIL  = COEF_W'(qmm_pkg::LIN_TAIL);
    localparam logic [NUM_SW-1:0]   NUM_HALF   = NUM_SW'(qmm_pkg::LIN_HALF);
    localparam logic [PL_W-1:0]     RECIP_C    = PL_W'(qmm_pkg::RECIP);
    localparam logic [PS_W-1:0]     SCALE_HALF = PS_W'(1 << (qmm_pkg::SCALE_SHIFT - 1));
    localparam logic [SCALED_W-1:0] S_NINETY   = SCALED_W'(qmm_pkg::NINETY);
    localparam logic [SCALED_W-1:0] S_TWENTY   = SCALED_W'(qmm_pkg::TWENTY);

    logic              raw_low, raw_high;
    logic [U_W-1:0]    n_rc;
    logic [COEF_W-1:0] n_coef;
    logic [NUM_SW-1:0] num;
    logic [PL_W-1:0]   prod_l;
    logic [PS_W-1:0]   prod_s;
    logic              n_high;
    logic [U_W-1:0]    n_motor;

    logic [U_W-1:0]      r_rc;
    logic [COEF_W-1:0]   r_coef;
    logic [X_W-1:0]      r_x;
    logic [U_W-1:0]      r_lin;
    logic [SCALED_W-1:0] r_scaled;
    logic [U_W-1:0]      r_motor;
    logic                r_lo_a, r_lo_b, r_lo_c, r_lo_d, r_lo_e, r_high;

    // clamp to 0..100 % and build r*11 + 9H
    always_comb begin
        raw_low  = i_raw[RAW_W-1] || (i_raw == RAW_W'(0));
        raw_high = !i_raw[RAW_W-1] && (i_raw >= RAW_FULL);
        if (raw_low) begin
            n_rc = '0;
        end else if (raw_high) begin
            n_rc = LIN_FULL;
        end else begin
            n_rc = i_raw[U_W-1:0];
        end
        n_coef = COEF_BASE + COEF_W'(n_rc) * COEF_TAIL;
    end

    // numerator, half-up rounding, power-of-two part of the divisor
    assign num = NUM_SW'(r_rc) * NUM_SW'(r_coef) + NUM_HALF;

    // remaining /125 by reciprocal, exact over the whole range
    assign prod_l = PL_W'(r_x) * RECIP_C;

    assign prod_s = PS_W'(r_lin) * PS_W'(i_scale) + SCALE_HALF;

    always_comb begin
        n_high = (r_scaled >= S_NINETY);
        if (n_high) begin
            n_motor = U_W'(S_NINETY);
        end else if (r_scaled < S_TWENTY) begin
            n_motor = U_W'(S_TWENTY);
        end else begin
            n_motor = r_scaled[U_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.clamp) begin
            r_rc   <= n_rc;
            r_coef <= n_coef;
            r_lo_a <= raw_low;
        end
        if (i_en.lin_mul) begin
            r_x    <= num[qmm_pkg::LIN_SHIFT +: X_W];
            r_lo_b <= r_lo_a;
        end
        if (i_en.recip) begin
            r_lin  <= prod_l[qmm_pkg::RECIP_SHIFT +: U_W];
            r_lo_c <= r_lo_b;
        end
        if (i_en.scale) begin
            r_scaled <= prod_s[qmm_pkg::SCALE_SHIFT +: SCALED_W];
            r_lo_d   <= r_lo_c;
        end
        if (i_en.sat) begin
            r_motor <= n_motor;
            r_high  <= n_high;
            r_lo_e  <= r_lo_d;
        end
    end

    assign o_motor    = r_motor;
    assign o_low_sat  = r_lo_e;
    assign o_high_sat = r_high;

endmodule

[rtl/quad_motor_mixer_core.sv]
// Quadcopter motor mixer, plus or X frame.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer carries thrust,
// roll, pitch and yaw in percent with FRAC_BITS fraction bits.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transfer per input,
// four motor commands clamped to 20..90 % plus low and high saturation flags.
// Throughput: one item per cycle while the receiver does not stall; eight register
// stages, each with a valid bit, set by the multiplier chain (diagonal weight,
// linearisation product, reciprocal divide by 125, motor scale).
// When the receiver stalls the items close up behind the output register;
// the block keeps taking input until every stage holds an item.
// Reset (synchronous, i_rst_n low) empties the pipeline and sets plus frame
// with unity scale on all motors.
// APB registers: 0x00 frame_mode, 0x04..0x10 scale_m1..m4 (Q2.12, clamped to
// 410..12288 on write). pready is tied high. Write only while idle.
`include "quad_motor_mixer_core_assert.svh"

module quad_motor_mixer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command in
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  qmm_pkg::t_cmd                      i_in_data,
    // motor commands out
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output qmm_pkg::t_mix                      o_out_data,
    // APB config
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qmm_pkg::ADDR_W-1:0]         paddr,
    input  logic [qmm_pkg::DATA_W-1:0]         pwdata,
    output logic [qmm_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int NSTG    = 8;
    localparam int NM      = qmm_pkg::NUM_MOTORS;
    localparam int U_W     = qmm_pkg::U_W;
    localparam int S_W     = qmm_pkg::S_W;
    localparam int D_W     = qmm_pkg::D_W;
    localparam int P_W     = qmm_pkg::P_W;
    localparam int RAW_W   = qmm_pkg::RAW_W;
    localparam int SCALE_W = qmm_pkg::SCALE_W;
    localparam int DATA_W  = qmm_pkg::DATA_W;

    localparam logic signed [qmm_pkg::DIAG_KW-1:0] DIAG_K_S =
        qmm_pkg::DIAG_KW'(qmm_pkg::DIAG_K);
    localparam logic signed [P_W-1:0] DIAG_HALF = P_W'(1 << (qmm_pkg::DIAG_SHIFT - 1));
    localparam logic [U_W-1:0] OUT_MIN = U_W'(qmm_pkg::TWENTY);
    localparam logic [U_W-1:0] OUT_MAX = U_W'(qmm_pkg::NINETY);

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    logic                     r_frame_mode;
    logic [SCALE_W-1:0]       r_scale [NM];
    logic                     cfg_wr;
    qmm_pkg::t_reg_idx        cfg_idx;
    logic [SCALE_W-1:0]       n_scale;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = qmm_pkg::t_reg_idx'(paddr[qmm_pkg::ADDR_W-1:2]);
    assign pready  = 1'b1;

    // out-of-range scales are pinned at write time
    always_comb begin
        n_scale = pwdata[SCALE_W-1:0];
        if (n_scale < qmm_pkg::SCALE_MIN) begin
            n_scale = qmm_pkg::SCALE_MIN;
        end else if (n_scale > qmm_pkg::SCALE_MAX) begin
            n_scale = qmm_pkg::SCALE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_mode <= qmm_pkg::FRAME_PLUS;
            for (int i = 0; i < NM; i++) begin
                r_scale[i] <= qmm_pkg::SCALE_ONE;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                qmm_pkg::REG_FRAME_MODE: r_frame_mode <= pwdata[0];
                qmm_pkg::REG_SCALE_M1:   r_scale[0]   <= n_scale;
                qmm_pkg::REG_SCALE_M2:   r_scale[1]   <= n_scale;
                qmm_pkg::REG_SCALE_M3:   r_scale[2]   <= n_scale;
                qmm_pkg::REG_SCALE_M4:   r_scale[3]   <= n_scale;
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            qmm_pkg::REG_FRAME_MODE: prdata = DATA_W'(r_frame_mode);
            qmm_pkg::REG_SCALE_M1:   prdata = DATA_W'(r_scale[0]);
            qmm_pkg::REG_SCALE_M2:   prdata = DATA_W'(r_scale[1]);
            qmm_pkg::REG_SCALE_M3:   prdata = DATA_W'(r_scale[2]);
            qmm_pkg::REG_SCALE_M4:   prdata = DATA_W'(r_scale[3]);
            default:                 prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when the next one
    // loads, so bubbles are squeezed out during an output stall
    //------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   rdy;

    always_comb begin
        rdy[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[NSTG-1];

    //------------------------------------------------------------------
    // stage 1: operands and diagonal differences
    //------------------------------------------------------------------
    logic signed [D_W-1:0] in_p, in_r;
    logic signed [D_W-1:0] n_diff [NM];
    logic        [U_W-1:0] r1_t;
    logic signed [S_W-1:0] r1_r, r1_p, r1_y;
    logic signed [D_W-1:0] r1_diff [NM];

    always_comb begin
        in_p      = D_W'(i_in_data.pitch_cmd);
        in_r      = D_W'(i_in_data.roll_cmd);
        n_diff[0] = in_p - in_r;
        n_diff[1] = -in_p - in_r;
        n_diff[2] = in_r - in_p;
        n_diff[3] = in_p + in_r;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_t    <= i_in_data.thrust_cmd;
            r1_r    <= i_in_data.roll_cmd;
            r1_p    <= i_in_data.pitch_cmd;
            r1_y    <= i_in_data.yaw_cmd;
            r1_diff <= n_diff;
        end
    end

    //------------------------------------------------------------------
    // stage 2: multiply by 1/sqrt(2) in Q0.16
    //------------------------------------------------------------------
    logic        [U_W-1:0] r2_t;
    logic signed [S_W-1:0] r2_r, r2_p, r2_y;
    logic signed [P_W-1:0] r2_prod [NM];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_t <= r1_t;
            r2_r <= r1_r;
            r2_p <= r1_p;
            r2_y <= r1_y;
            for (int i = 0; i < NM; i++) begin
                r2_prod[i] <= r1_diff[i] * DIAG_K_S;
            end
        end
    end

    //------------------------------------------------------------------
    // stage 3: round the diagonal terms (ties up) and form raw mixes
    //------------------------------------------------------------------
    logic signed [P_W-1:0]   rnd   [NM];
    logic signed [D_W-1:0]   kd    [NM];
    logic signed [RAW_W-1:0] plus_term [NM];
    logic signed [RAW_W-1:0] term  [NM];
    logic signed [RAW_W-1:0] t_ext, y_ext;
    logic signed [RAW_W-1:0] n_raw [NM];
    logic signed [RAW_W-1:0] r3_raw [NM];

    always_comb begin
        t_ext        = $signed(RAW_W'(r2_t));
        y_ext        = RAW_W'(r2_y);
        plus_term[0] = RAW_W'(r2_p);
        plus_term[1] = -RAW_W'(r2_r);
        plus_term[2] = -RAW_W'(r2_p);
        plus_term[3] = RAW_W'(r2_r);
        for (int i = 0; i < NM; i++) begin
            rnd[i]  = r2_prod[i] + DIAG_HALF;
            kd[i]   = $signed(rnd[i][qmm_pkg::DIAG_SHIFT +: D_W]);
            term[i] = (r_frame_mode == qmm_pkg::FRAME_X) ? RAW_W'(kd[i]) : plus_term[i];
            // yaw adds on motors 1 and 3, subtracts on 2 and 4
            n_raw[i] = ((i % 2) == 0) ? (t_ext + term[i] + y_ext)
                                      : (t_ext + term[i] - y_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_raw <= n_raw;
        end
    end

    //------------------------------------------------------------------
    // stages 4..8: per-motor linearise, scale, saturate
    //------------------------------------------------------------------
    qmm_pkg::t_lane_en  lane_en;
    logic [U_W-1:0]     lane_motor [NM];
    logic [NM-1:0]      lane_lo, lane_hi;

    assign lane_en.clamp   = rdy[3];
    assign lane_en.lin_mul = rdy[4];
    assign lane_en.recip   = rdy[5];
    assign lane_en.scale   = rdy[6];
    assign lane_en.sat     = rdy[7];

    for (genvar g = 0; g < NM; g++) begin : g_motor
        qmm_motor u_motor (
            .i_clk      (i_clk),
            .i_en       (lane_en),
            .i_raw      (r3_raw[g]),
            .i_scale    (r_scale[g]),
            .o_motor    (lane_motor[g]),
            .o_low_sat  (lane_lo[g]),
            .o_high_sat (lane_hi[g])
        );
    end

    always_comb begin
        o_out_data.motor1_out     = lane_motor[0];
        o_out_data.motor2_out     = lane_motor[1];
        o_out_data.motor3_out     = lane_motor[2];
        o_out_data.motor4_out     = lane_motor[3];
        o_out_data.low_sat_flags  = lane_lo;
        o_out_data.high_sat_flags = lane_hi;
    end

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    // input only blocks when every stage is full and the sink stalls
    `QMM_ASSERT_IMPL(a_block_only_full, !o_in_ready, o_out_valid && !i_out_ready)

    `QMM_ASSERT_IMPL(a_out_range, o_out_valid,
        (o_out_data.motor1_out >= OUT_MIN) && (o_out_data.motor1_out <= OUT_MAX) &&
        (o_out_data.motor2_out >= OUT_MIN) && (o_out_data.motor2_out <= OUT_MAX) &&
        (o_out_data.motor3_out >= OUT_MIN) && (o_out_data.motor3_out <= OUT_MAX) &&
        (o_out_data.motor4_out >= OUT_MIN) && (o_out_data.motor4_out <= OUT_MAX))

    // high flag set exactly when the motor sits on the upper clamp
    `QMM_ASSERT_IMPL(a_high_flag, o_out_valid,
        (o_out_data.high_sat_flags[0] == (o_out_data.motor1_out == OUT_MAX)) &&
        (o_out_data.high_sat_flags[1] == (o_out_data.motor2_out == OUT_MAX)) &&
        (o_out_data.high_sat_flags[2] == (o_out_data.motor3_out == OUT_MAX)) &&
        (o_out_data.high_sat_flags[3] == (o_out_data.motor4_out == OUT_MAX)))

    // motor 1, when mixed at or below zero, ends on the lower clamp
    `QMM_ASSERT_IMPL(a_low_flag_m1, o_out_valid && o_out_data.low_sat_flags[0],
        (o_out_data.motor1_out == OUT_MIN) && !o_out_data.high_sat_flags[0])

    `QMM_ASSERT_ALWAYS(a_scale_range,
        (r_scale[0] >= qmm_pkg::SCALE_MIN) && (r_scale[0] <= qmm_pkg::SCALE_MAX) &&
        (r_scale[1] >= qmm_pkg::SCALE_MIN) && (r_scale[1] <= qmm_pkg::SCALE_MAX) &&
        (r_scale[2] >= qmm_pkg::SCALE_MIN) && (r_scale[2] <= qmm_pkg::SCALE_MAX) &&
        (r_scale[3] >= qmm_pkg::SCALE_MIN) && (r_scale[3] <= qmm_pkg::SCALE_MAX))

endmodule

[tb/sv/testbench.sv]
module testbench;
    import qmm_pkg::*;

    localparam int LATENCY           = 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int NUM_REGS          = 5;
    localparam int ITEMS_PER_SETTING = 165;
    localparam longint ROUND_DIAG    = longint'(1) << (DIAG_SHIFT - 1);
    localparam longint ROUND_SCALE   = longint'(1) << (SCALE_SHIFT - 1);

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_cmd              in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_mix              out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Mirror of the block's registers, updated as each write goes out.
    logic               cfg_frame;
    logic [SCALE_W-1:0] cfg_scale [NUM_MOTORS];

    // Motor commands still owed by the block, oldest first.
    t_mix pending_mix [$];

    int errors        = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    quad_motor_mixer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Mixer arithmetic
    // ------------------------------------------------------------------

    // Diagonal weight in Q0.16, rounded to the input grid, ties upwards.
    // An arithmetic shift of (v + half) floors, which gives exactly that.
    function automatic longint diag_term(longint d);
        return (d * DIAG_K + ROUND_DIAG) >>> DIAG_SHIFT;
    endfunction

    function automatic t_mix mix_motors(t_cmd c);
        longint         t, r, p, y, lin, s;
        longint         raw   [NUM_MOTORS];
        logic [U_W-1:0] level [NUM_MOTORS];
        t_mix           m;
        t = longint'(c.thrust_cmd);
        r = longint'($signed(c.roll_cmd));
        p = longint'($signed(c.pitch_cmd));
        y = longint'($signed(c.yaw_cmd));
        if (cfg_frame == FRAME_X) begin
            raw[0] = t + diag_term(p - r) + y;
            raw[1] = t + diag_term(-p - r) - y;
            raw[2] = t + diag_term(r - p) + y;
            raw[3] = t + diag_term(p + r) - y;
        end else begin
            raw[0] = t + p + y;
            raw[1] = t - r - y;
            raw[2] = t - p + y;
            raw[3] = t + r - y;
        end
        m.low_sat_flags  = '0;
        m.high_sat_flags = '0;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            // thrust curve 0.45r + 0.55r^2/100, clipped to 0..100 %, half up
            if (raw[i] <= 0) begin
                lin = 0;
            end else if (raw[i] >= HUNDRED) begin
                lin = HUNDRED;
            end else begin
                lin = (45 * raw[i] * HUNDRED + 55 * raw[i] * raw[i] + 50 * HUNDRED)
                      / (100 * HUNDRED);
            end
            s = (lin * longint'(cfg_scale[i]) + ROUND_SCALE) >>> SCALE_SHIFT;
            m.low_sat_flags[i]  = (raw[i] <= 0);
            m.high_sat_flags[i] = (s >= NINETY);
            if (s < TWENTY) begin
                s = TWENTY;
            end else if (s > NINETY) begin
                s = NINETY;
            end
            level[i] = U_W'(s);
        end
        m.motor1_out = level[0];
        m.motor2_out = level[1];
        m.motor3_out = level[2];
        m.motor4_out = level[3];
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_cmd make_cmd(int t, int r, int p, int y);
        t_cmd c;
        c.thrust_cmd = U_W'(t);
        c.roll_cmd   = S_W'(r);
        c.pitch_cmd  = S_W'(p);
        c.yaw_cmd    = S_W'(y);
        return c;
    endfunction

    // Mostly legal commands, a band near hover with small torques, and a
    // share of raw bit patterns so every input bit toggles.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   sel, span;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            c.thrust_cmd = U_W'($urandom());
            c.roll_cmd   = S_W'($urandom());
            c.pitch_cmd  = S_W'($urandom());
            c.yaw_cmd    = S_W'($urandom());
        end else begin
            span = (sel < 45) ? 2560 : HUNDRED;
            if (sel < 45) begin
                c.thrust_cmd = U_W'($urandom_range(6400, 19200));
            end else begin
                c.thrust_cmd = U_W'($urandom_range(0, HUNDRED));
            end
            c.roll_cmd  = S_W'(int'($urandom_range(0, 2 * span)) - span);
            c.pitch_cmd = S_W'(int'($urandom_range(0, 2 * span)) - span);
            c.yaw_cmd   = S_W'(int'($urandom_range(0, 2 * span)) - span);
        end
        return c;
    endfunction

    // Entered and left at a falling edge. Random idle cycles go before the
    // transfer; valid is held until the block takes the command.
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!in_ready);
        pending_mix.push_back(mix_motors(c));
        @(negedge clk);
    endtask

    // Drop valid, then wait until every owed result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        logic [SCALE_W-1:0] s;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // scales keep only their 14 bits and are clipped to 0.1..3.0
        s = value[SCALE_W-1:0];
        if (idx == REG_FRAME_MODE) begin
            cfg_frame = value[0];
        end else if (idx >= REG_SCALE_M1 && idx <= REG_SCALE_M4) begin
            if (s < SCALE_MIN) begin
                s = SCALE_MIN;
            end else if (s > SCALE_MAX) begin
                s = SCALE_MAX;
            end
            cfg_scale[idx - REG_SCALE_M1] = s;
        end
    endtask

    task automatic check_reg(logic [REG_IDX_W-1:0] idx);
        logic [DATA_W-1:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_FRAME_MODE) begin
            want = DATA_W'(cfg_frame);
        end else begin
            want = DATA_W'(cfg_scale[idx - REG_SCALE_M1]);
        end
        if (prdata !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [DATA_W-1:0] frame, logic [DATA_W-1:0] s1,
                              logic [DATA_W-1:0] s2, logic [DATA_W-1:0] s3,
                              logic [DATA_W-1:0] s4);
        apb_write(REG_FRAME_MODE, frame);
        apb_write(REG_SCALE_M1, s1);
        apb_write(REG_SCALE_M2, s2);
        apb_write(REG_SCALE_M3, s3);
        apb_write(REG_SCALE_M4, s4);
        for (int i = 0; i < NUM_REGS; i++) check_reg(REG_IDX_W'(i));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_values;
        for (int i = 0; i < NUM_REGS; i++) check_reg(REG_IDX_W'(i));
    endtask

    // Plus frame at unity scale: idle, full, over-range thrust and torque
    // extremes on each axis, which drive motors into both clamps.
    task automatic test_plus_frame;
        set_config(FRAME_PLUS, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        send_cmd(make_cmd(0, 0, 0, 0));
        send_cmd(make_cmd(HUNDRED, 0, 0, 0));
        send_cmd(make_cmd(32767, 0, 0, 0));
        send_cmd(make_cmd(1, 0, 0, 0));
        send_cmd(make_cmd(HUNDRED - 1, 0, 0, 0));
        send_cmd(make_cmd(12800, 0, 25600, 0));
        send_cmd(make_cmd(12800, -25600, 0, 0));
        send_cmd(make_cmd(12800, 0, 0, 25600));
        send_cmd(make_cmd(0, -32768, -32768, -32768));
        send_cmd(make_cmd(32767, 32767, 32767, 32767));
        send_cmd(make_cmd(32767, -32768, 32767, -32768));
        drain;
    endtask

    // X frame: differences of exactly +/-32768 land on a rounding tie,
    // plus the widest differences the fields allow.
    task automatic test_x_frame;
        set_config(FRAME_X, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        send_cmd(make_cmd(12800, -16384, 16384, 0));
        send_cmd(make_cmd(12800, 16384, -16384, 0));
        send_cmd(make_cmd(12800, 16384, 16384, 0));
        send_cmd(make_cmd(32767, -32768, 32767, 0));
        send_cmd(make_cmd(0, 32767, -32768, 0));
        // -p-r = +65536 and p+r = -65536
        send_cmd(make_cmd(12800, -32768, -32768, 0));
        send_cmd(make_cmd(HUNDRED, 0, 0, -25600));
        drain;
    endtask

    // Out-of-range scale writes are clipped, bits above the field dropped,
    // frame takes bit 0 only. Then a scale of 1.125 walks motors across 90 %.
    task automatic test_scale_limits;
        set_config(32'h2, 32'h0, 32'h0001_0000 | 32'd5000, 32'd12289, 32'hFFFF_FFFF);
        send_cmd(make_cmd(HUNDRED, 0, 0, 0));
        send_cmd(make_cmd(12800, 3000, -2000, 1000));
        drain;
        set_config(32'h3, 32'd409, 32'd410, 32'd12288, 32'd4608);
        send_cmd(make_cmd(HUNDRED, 0, 0, 0));
        send_cmd(make_cmd(6400, 0, 0, 0));
        drain;
        set_config(FRAME_PLUS, 32'd4608, 32'd4608, 32'd4608, 32'd4608);
        send_cmd(make_cmd(22130, 2, 1, 0));
        send_cmd(make_cmd(22135, 4, -3, 0));
        drain;
    endtask

    // Addresses past the last register must leave the map alone.
    task automatic test_unmapped_registers;
        for (int i = NUM_REGS; i < (1 << REG_IDX_W); i++) begin
            apb_write(REG_IDX_W'(i), $urandom());
        end
        for (int i = 0; i < NUM_REGS; i++) check_reg(REG_IDX_W'(i));
        send_cmd(make_cmd(12800, 1000, -1000, 500));
        drain;
    endtask

    // Four handshake phases, two settings each; extremes of frame and
    // scale first, random settings later.
    task automatic test_random_traffic;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (int k = 0; k < 2; k++) begin
                case (ph * 2 + k)
                    0: set_config(FRAME_PLUS, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
                    1: set_config(FRAME_X, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
                    2: set_config(FRAME_X, SCALE_MIN, SCALE_MIN, SCALE_MIN, SCALE_MIN);
                    3: set_config(FRAME_PLUS, SCALE_MAX, SCALE_MIN, SCALE_ONE, SCALE_MAX);
                    default: set_config($urandom_range(0, 1),
                                        $urandom_range(SCALE_MIN, SCALE_MAX),
                                        $urandom_range(SCALE_MIN, SCALE_MAX),
                                        $urandom_range(SCALE_MIN, SCALE_MAX),
                                        $urandom_range(SCALE_MIN, SCALE_MAX));
                endcase
                repeat (ITEMS_PER_SETTING) send_cmd(random_cmd());
                drain;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        t_mix want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_mix.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", out_data);
                errors++;
            end else begin
                want = pending_mix.pop_front();
                check_field("motor1_out", want.motor1_out, out_data.motor1_out);
                check_field("motor2_out", want.motor2_out, out_data.motor2_out);
                check_field("motor3_out", want.motor3_out, out_data.motor3_out);
                check_field("motor4_out", want.motor4_out, out_data.motor4_out);
                check_field("low_sat_flags", want.low_sat_flags, out_data.low_sat_flags);
                check_field("high_sat_flags", want.high_sat_flags, out_data.high_sat_flags);
            end
        end
    end

    // Hang detector: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[quad_motor_mixer_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        cfg_frame = FRAME_PLUS;
        for (int i = 0; i < NUM_MOTORS; i++) cfg_scale[i] = SCALE_ONE;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values;
        test_plus_frame;
        test_x_frame;
        test_scale_limits;
        test_unmapped_registers;
        test_random_traffic;

        if (errors == 0) begin
            $display("[quad_motor_mixer_core] OK");
        end else begin
            $display("[quad_motor_mixer_core] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/qmm_pkg.sv
rtl/qmm_motor.sv
rtl/quad_motor_mixer_core.sv
tb/sv/testbench.sv
